// ===== hdl/almb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// almb_pkg: shared types and constants
// Register indexes, the classified work item and level constants.
// ----------------------------------------------------------------------------
package almb_pkg;

  localparam logic signed [15:0] SILENCE = 16'sh8000;

  typedef enum logic [2:0] {
    REG_MIN_LEVEL  = 3'd0,
    REG_MIN_INPUT  = 3'd1,
    REG_WARNING    = 3'd2,
    REG_ERROR      = 3'd3,
    REG_PEAK_DECAY = 3'd4,
    REG_MAG_GAIN   = 3'd5,
    REG_PEAK_HOLD  = 3'd6,
    REG_INPUT_HOLD = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    CLS_BELOW   = 3'd0,
    CLS_NOMINAL = 3'd1,
    CLS_WARNING = 3'd2,
    CLS_ERROR   = 3'd3,
    CLS_CLIP    = 3'd4
  } level_class_e;

  // One accepted update with its channel already checked.
  typedef struct packed {
    logic [4:0]         channel;
    logic [31:0]        now_ms;
    logic [15:0]        elapsed_ms;
    logic signed [15:0] magnitude;
    logic signed [15:0] peak;
    logic signed [15:0] input_peak;
  } work_t;

endpackage
`default_nettype wire

// ===== hdl/almb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// almb_front: input classification and work queue
// Drops updates for absent channels and queues the rest for the back end.
// ----------------------------------------------------------------------------
module almb_front import almb_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         channel_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic [15:0]        elapsed_ms_i,
  input  wire logic signed [15:0] new_magnitude_i,
  input  wire logic signed [15:0] new_peak_i,
  input  wire logic signed [15:0] new_input_peak_i,
  output logic                    wq_valid_o,
  input  wire logic               wq_pop_i,
  output work_t                   wq_item_o
);

  localparam int Depth = 2;

  work_t      mem_q [Depth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop, keep;

  assign in_stall_o = (cnt_q == 2'(Depth));
  // Updates for channels that do not exist are taken and discarded.
  assign keep = 6'(channel_i) < 6'(CHANNELS);
  assign push = in_valid_i && !in_stall_o && keep;
  assign pop  = wq_pop_i && wq_valid_o;
  assign wq_valid_o = (cnt_q != 2'd0);
  assign wq_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{channel: {2'b00, channel_i}, now_ms: now_ms_i,
                       elapsed_ms: elapsed_ms_i, magnitude: new_magnitude_i,
                       peak: new_peak_i, input_peak: new_input_peak_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/almb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// almb_back: ballistics sequencer
// Updates one channel's state over six steps with narrow multipliers.
// ----------------------------------------------------------------------------
module almb_back import almb_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int CLIP_LEVEL = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wq_valid_i,
  output logic                    wq_pop_o,
  input  work_t                   wq_item_i,
  input  wire logic signed [15:0] min_level_i,
  input  wire logic signed [15:0] min_input_i,
  input  wire logic signed [15:0] warning_i,
  input  wire logic signed [15:0] error_i,
  input  wire logic [15:0]        peak_decay_i,
  input  wire logic [15:0]        mag_gain_i,
  input  wire logic [31:0]        peak_hold_ms_i,
  input  wire logic [31:0]        input_hold_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              out_channel_o,
  output logic signed [15:0]      shown_peak_o,
  output logic signed [15:0]      shown_peak_hold_o,
  output logic signed [15:0]      shown_magnitude_o,
  output logic signed [15:0]      shown_input_hold_o,
  output logic [2:0]              input_class_o
);

  localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [16:0] Clip = 17'(CLIP_LEVEL);
  // Reciprocal of 125 scaled by 2^30, rounded up.
  localparam logic [23:0] Recip125 = 24'd8589935;
  // Sums at or above these give quotients of 65536 or more.
  localparam logic [32:0] DecSat = 33'd65536000;
  localparam logic [48:0] MagSat = 49'd16777216000;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_MUL2 = 7'b0000100,
    ST_MUL3 = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_DONE = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [15:0] peak_q  [CHANNELS];
  logic signed [15:0] phold_q [CHANNELS];
  logic [31:0]        ptime_q [CHANNELS];
  logic signed [15:0] ihold_q [CHANNELS];
  logic [31:0]        itime_q [CHANNELS];
  logic signed [15:0] mag_q   [CHANNELS];

  work_t              w_q;
  logic [ChW-1:0]     ch;
  logic [31:0]        prod_q;   // decay * elapsed
  logic [31:0]        gprod_q;  // |diff| * gain
  logic [47:0]        prod2_q;  // (|diff| * gain) * elapsed
  logic [16:0]        absd_q;
  logic               neg_q;
  logic [16:0]        dec_q;    // rounded decay, saturated at 65536
  logic [16:0]        q_q;      // rounded magnitude step, saturated at 65536

  logic signed [16:0] diff;
  logic [32:0]        dec_sum;
  logic [48:0]        mag_sum;
  logic [22:0]        rcp_in;
  logic [46:0]        rcp_prod;

  assign ch   = w_q.channel[ChW-1:0];
  assign diff = 17'(w_q.magnitude) - 17'(mag_q[ch]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (wq_valid_i) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_DIV;
      ST_DIV:  state_d = ST_DONE;
      ST_DONE: state_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign wq_pop_o    = (state_q == ST_IDLE) && wq_valid_i;
  assign out_valid_o = (state_q == ST_OUT);

  // Division by 1000 or 256000: drop the power-of-two factor, then multiply
  // by the reciprocal of 125. Exact for every quotient below 65536.
  assign dec_sum  = 33'(prod_q) + 33'd500;
  assign mag_sum  = 49'(prod2_q) + 49'd128000;
  assign rcp_in   = (state_q == ST_MUL2) ? dec_sum[25:3] : mag_sum[33:11];
  assign rcp_prod = 47'(rcp_in) * 47'(Recip125);

  // Result computation from the rounded quotients.
  logic signed [17:0] pk_sub, pk_lo;
  logic signed [15:0] pk_new, ph_new, ih_new, mg_new;
  logic [31:0]        pt_new, it_new;
  logic signed [17:0] msum;
  logic signed [15:0] h;
  logic [2:0]         cls;

  always_comb begin
    pk_lo  = (w_q.peak < 0) ? 18'(w_q.peak) : 18'sd0;
    pk_sub = 18'(peak_q[ch]) - $signed({1'b0, dec_q});
    if (w_q.peak >= peak_q[ch] || peak_q[ch] == SILENCE) pk_new = w_q.peak;
    else if (pk_sub < pk_lo) pk_new = pk_lo[15:0];
    else if (pk_sub > 0) pk_new = 16'sd0;
    else pk_new = pk_sub[15:0];

    ph_new = phold_q[ch];
    pt_new = ptime_q[ch];
    if (w_q.peak >= phold_q[ch] || phold_q[ch] == SILENCE ||
        (w_q.now_ms - ptime_q[ch]) > peak_hold_ms_i) begin
      ph_new = w_q.peak;
      pt_new = w_q.now_ms;
    end
    ih_new = ihold_q[ch];
    it_new = itime_q[ch];
    if (w_q.input_peak >= ihold_q[ch] || ihold_q[ch] == SILENCE ||
        (w_q.now_ms - itime_q[ch]) > input_hold_ms_i) begin
      ih_new = w_q.input_peak;
      it_new = w_q.now_ms;
    end

    msum = 18'(mag_q[ch]) +
           (neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q}));
    if (mag_q[ch] == SILENCE) mg_new = (w_q.magnitude > 0) ? 16'sd0 : w_q.magnitude;
    else if (w_q.magnitude == SILENCE) mg_new = (min_level_i > 0) ? 16'sd0 : min_level_i;
    else if (msum > 0) mg_new = 16'sd0;
    else if (msum < 18'(min_level_i)) mg_new = (min_level_i > 0) ? 16'sd0 : min_level_i;
    else mg_new = msum[15:0];

    h = ih_new;
    if (h == SILENCE || h < min_input_i) cls = CLS_BELOW;
    else if (h < warning_i) cls = CLS_NOMINAL;
    else if (h < error_i) cls = CLS_WARNING;
    else if (17'(h) < Clip) cls = CLS_ERROR;
    else cls = CLS_CLIP;
  end

  always_ff @(posedge clk_i) begin
    if (wq_pop_o) w_q <= wq_item_i;
    if (state_q == ST_MUL1) begin
      prod_q <= 32'(peak_decay_i) * 32'(w_q.elapsed_ms);
      absd_q <= diff[16] ? 17'(-diff) : 17'(diff);
      neg_q  <= diff[16];
    end
    if (state_q == ST_MUL2) begin
      gprod_q <= 32'(absd_q) * 32'(mag_gain_i);
      dec_q   <= (dec_sum >= DecSat) ? 17'd65536 : rcp_prod[46:30];
    end
    if (state_q == ST_MUL3) begin
      prod2_q <= 48'(gprod_q) * 48'(w_q.elapsed_ms);
    end
    if (state_q == ST_DIV) begin
      q_q <= (mag_sum >= MagSat) ? 17'd65536 : rcp_prod[46:30];
    end
    if (state_q == ST_DONE) begin
      out_channel_o      <= w_q.channel[2:0];
      shown_peak_o       <= pk_new;
      shown_peak_hold_o  <= ph_new;
      shown_magnitude_o  <= mg_new;
      shown_input_hold_o <= ih_new;
      input_class_o      <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        peak_q[i]  <= SILENCE;
        phold_q[i] <= SILENCE;
        ptime_q[i] <= '0;
        ihold_q[i] <= SILENCE;
        itime_q[i] <= '0;
        mag_q[i]   <= SILENCE;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE) begin
        peak_q[ch]  <= pk_new;
        phold_q[ch] <= ph_new;
        ptime_q[ch] <= pt_new;
        ihold_q[ch] <= ih_new;
        itime_q[ch] <= it_new;
        mag_q[ch]   <= mg_new;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/audio_level_meter_ballistics_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_level_meter_ballistics_unit: per-channel level meter ballistics
// Each accepted transfer passes through the back-end states MUL1, MUL2, MUL3, DIV,
// DONE and OUT before its result transfer; the back-end sequencer takes one item
// at a time and splits the decay, smoothing and rounding products over four steps.
// A two-entry queue lets the input side keep taking transfers meanwhile, until it fills.
// Reset clears all channel state to silence and the registers to defaults.
// ----------------------------------------------------------------------------
module audio_level_meter_ballistics_unit import almb_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int CLIP_LEVEL = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         channel_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic [15:0]        elapsed_ms_i,
  input  wire logic signed [15:0] new_magnitude_i,
  input  wire logic signed [15:0] new_peak_i,
  input  wire logic signed [15:0] new_input_peak_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              out_channel_o,
  output logic signed [15:0]      shown_peak_o,
  output logic signed [15:0]      shown_peak_hold_o,
  output logic signed [15:0]      shown_magnitude_o,
  output logic signed [15:0]      shown_input_hold_o,
  output logic [2:0]              input_class_o
);

  // Configuration registers, word addressed.
  logic [15:0] min_level_q, min_input_q, warning_q, error_q, decay_q, gain_q;
  logic [31:0] phold_ms_q, ihold_ms_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q <= 16'hC400;
      min_input_q <= 16'hCE00;
      warning_q   <= 16'hEC00;
      error_q     <= 16'hF700;
      decay_q     <= 16'd3011;
      gain_q      <= 16'd845;
      phold_ms_q  <= 32'd20000;
      ihold_ms_q  <= 32'd1000;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_LEVEL:  min_level_q <= pwdata[15:0];
        REG_MIN_INPUT:  min_input_q <= pwdata[15:0];
        REG_WARNING:    warning_q   <= pwdata[15:0];
        REG_ERROR:      error_q     <= pwdata[15:0];
        REG_PEAK_DECAY: decay_q     <= pwdata[15:0];
        REG_MAG_GAIN:   gain_q      <= pwdata[15:0];
        REG_PEAK_HOLD:  phold_ms_q  <= pwdata;
        REG_INPUT_HOLD: ihold_ms_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_LEVEL:  prdata = {16'h0, min_level_q};
      REG_MIN_INPUT:  prdata = {16'h0, min_input_q};
      REG_WARNING:    prdata = {16'h0, warning_q};
      REG_ERROR:      prdata = {16'h0, error_q};
      REG_PEAK_DECAY: prdata = {16'h0, decay_q};
      REG_MAG_GAIN:   prdata = {16'h0, gain_q};
      REG_PEAK_HOLD:  prdata = phold_ms_q;
      REG_INPUT_HOLD: prdata = ihold_ms_q;
      default:        prdata = '0;
    endcase
  end

  logic  wq_valid, wq_pop;
  work_t wq_item;

  // Front end: checks the channel and queues the update.
  almb_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .channel_i, .now_ms_i,
    .elapsed_ms_i, .new_magnitude_i, .new_peak_i, .new_input_peak_i,
    .wq_valid_o(wq_valid), .wq_pop_i(wq_pop), .wq_item_o(wq_item)
  );

  // Back end: runs the ballistics on one channel at a time.
  almb_back #(.CHANNELS(CHANNELS), .CLIP_LEVEL(CLIP_LEVEL)) u_back (
    .clk_i, .rst_ni, .wq_valid_i(wq_valid), .wq_pop_o(wq_pop),
    .wq_item_i(wq_item),
    .min_level_i($signed(min_level_q)), .min_input_i($signed(min_input_q)),
    .warning_i($signed(warning_q)), .error_i($signed(error_q)),
    .peak_decay_i(decay_q), .mag_gain_i(gain_q),
    .peak_hold_ms_i(phold_ms_q), .input_hold_ms_i(ihold_ms_q),
    .out_valid_o, .out_stall_i, .out_channel_o, .shown_peak_o,
    .shown_peak_hold_o, .shown_magnitude_o, .shown_input_hold_o, .input_class_o
  );

  // The queue is never popped while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wq_pop |-> wq_valid)
    else $error("work queue popped while empty");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shown_magnitude_o))
    else $error("result changed under stall");

  // The smoothed magnitude never exceeds zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shown_magnitude_o <= 16'sh0)
    else $error("magnitude above zero");

endmodule
`default_nettype wire

// ===== tb/sv/audio_level_meter_ballistics_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_level_meter_ballistics_unit_tb: self-checking bench for the meter
// Drives channel updates and register writes, predicts every result from an
// internal copy of the per-channel meter state and compares each transfer.
// ----------------------------------------------------------------------------

// One result as seen on the output ports.
typedef struct {
  logic [2:0]         ch;
  logic signed [15:0] pk;
  logic signed [15:0] pkh;
  logic signed [15:0] mag;
  logic signed [15:0] inh;
  logic [2:0]         cls;
} meter_view_t;

// Scoreboard: holds the meter state model and the queue of expected results.
class meter_scoreboard;
  logic [31:0] regs [8];
  int          peak   [8];
  int          peak_h [8];
  logic [31:0] peak_t [8];
  int          in_h   [8];
  logic [31:0] in_t   [8];
  int          mag_s  [8];
  meter_view_t pending [$];
  int          errors;

  function new();
    regs[0] = 32'hC400; regs[1] = 32'hCE00; regs[2] = 32'hEC00; regs[3] = 32'hF700;
    regs[4] = 3011; regs[5] = 845; regs[6] = 20000; regs[7] = 1000;
    for (int i = 0; i < 8; i++) begin
      peak[i] = -32768; peak_h[i] = -32768; in_h[i] = -32768; mag_s[i] = -32768;
      peak_t[i] = 0; in_t[i] = 0;
    end
    errors = 0;
  endfunction

  function int sreg(int i);
    logic signed [15:0] v;
    v = regs[i][15:0];
    return int'(v);
  endfunction

  // Holds follow rises, take any value over silence and re-arm after expiry.
  function void hold_update(ref int hv, ref logic [31:0] ht, input int v,
                            input logic [31:0] now, input logic [31:0] life);
    logic [31:0] age;
    age = now - ht;
    if (v >= hv || hv == -32768 || age > life) begin
      hv = v;
      ht = now;
    end
  endfunction

  function void note_update(logic [2:0] ch, logic [31:0] now, logic [15:0] el,
                            logic signed [15:0] m, logic signed [15:0] p,
                            logic signed [15:0] ip);
    meter_view_t e;
    longint d, lo, x, diff, q;
    longint unsigned mu;
    int h;
    if (p >= peak[ch] || peak[ch] == -32768) peak[ch] = int'(p);
    else begin
      d  = (longint'(regs[4][15:0]) * el + 500) / 1000;
      lo = (p < 0) ? p : 0;
      x  = peak[ch] - d;
      if (x < lo) x = lo;
      if (x > 0) x = 0;
      peak[ch] = int'(x);
    end
    hold_update(peak_h[ch], peak_t[ch], int'(p), now, regs[6]);
    hold_update(in_h[ch], in_t[ch], int'(ip), now, regs[7]);
    if (mag_s[ch] == -32768) mag_s[ch] = (m > 0) ? 0 : int'(m);
    else if (m == -32768) mag_s[ch] = (sreg(0) > 0) ? 0 : sreg(0);
    else begin
      diff = longint'(m) - mag_s[ch];
      mu = (diff < 0) ? -diff : diff;
      q = (mu * regs[5][15:0] * el + 128000) / 256000;
      x = mag_s[ch] + ((diff < 0) ? -q : q);
      if (x < sreg(0)) x = sreg(0);
      if (x > 0) x = 0;
      mag_s[ch] = int'(x);
    end
    h = in_h[ch];
    if (h == -32768 || h < sreg(1)) e.cls = almb_pkg::CLS_BELOW;
    else if (h < sreg(2)) e.cls = almb_pkg::CLS_NOMINAL;
    else if (h < sreg(3)) e.cls = almb_pkg::CLS_WARNING;
    else if (h < 0) e.cls = almb_pkg::CLS_ERROR;
    else e.cls = almb_pkg::CLS_CLIP;
    e.ch = ch; e.pk = 16'(peak[ch]); e.pkh = 16'(peak_h[ch]);
    e.mag = 16'(mag_s[ch]); e.inh = 16'(h);
    pending.push_back(e);
  endfunction

  function void check_result(meter_view_t got);
    meter_view_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result on channel %0d", $time, got.ch);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.ch !== got.ch || e.pk !== got.pk || e.pkh !== got.pkh ||
        e.mag !== got.mag || e.inh !== got.inh || e.cls !== got.cls) begin
      $display("%0t: mismatch expected ch%0d pk%0d ph%0d mg%0d ih%0d c%0d", $time,
               e.ch, e.pk, e.pkh, e.mag, e.inh, e.cls);
      $display("%0t:          actual   ch%0d pk%0d ph%0d mg%0d ih%0d c%0d", $time,
               got.ch, got.pk, got.pkh, got.mag, got.inh, got.cls);
      errors++;
    end
  endfunction
endclass

module audio_level_meter_ballistics_unit_tb;
  import almb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] channel_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [15:0] elapsed_ms_i = '0;
  logic signed [15:0] new_magnitude_i = '0, new_peak_i = '0, new_input_peak_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] out_channel_o, input_class_o;
  logic signed [15:0] shown_peak_o, shown_peak_hold_o, shown_magnitude_o;
  logic signed [15:0] shown_input_hold_o;

  audio_level_meter_ballistics_unit dut (.*);

  meter_scoreboard meter_sb = new();

  // Idle percentages per phase for the sender and the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;
  logic [31:0] clock_ms = 0;

  initial forever #2 clk_i = ~clk_i;

  // Watchdog: the slowest legal run is far below this bound.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: sample each result transfer at the rising edge, then redraw stall.
  always @(posedge clk_i) begin
    meter_view_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ch = out_channel_o; got.pk = shown_peak_o; got.pkh = shown_peak_hold_o;
      got.mag = shown_magnitude_o; got.inh = shown_input_hold_o;
      got.cls = input_class_o;
      meter_sb.check_result(got);
    end
  end

  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // A register write: setup cycle, then the access cycle where it lands.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    meter_sb.regs[idx] = (idx < REG_PEAK_HOLD) ? {16'h0, value[15:0]} : value;
  endtask

  // One input transfer, with a random gap before it as the phase asks.
  task automatic send_update(logic [2:0] ch, logic [31:0] now, logic [15:0] el,
                             logic signed [15:0] m, logic signed [15:0] p,
                             logic signed [15:0] ip);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1; channel_i <= ch; now_ms_i <= now; elapsed_ms_i <= el;
    new_magnitude_i <= m; new_peak_i <= p; new_input_peak_i <= ip;
    do @(posedge clk_i); while (in_stall_o);
    meter_sb.note_update(ch, now, el, m, p, ip);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait for every expected result, plus the pipeline latency margin.
  task automatic drain();
    while (meter_sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Mostly realistic meter levels, sometimes silence or full-range noise.
  function automatic logic signed [15:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 8) return SILENCE;
    if (r < 18) return 16'($urandom);
    if (r < 24) return 16'($urandom_range(2560));
    return -16'($urandom_range(15360));
  endfunction

  task automatic random_updates(int count);
    logic [15:0] el;
    for (int i = 0; i < count; i++) begin
      el = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(200));
      clock_ms = clock_ms + el;
      if ($urandom_range(19) == 0) clock_ms = $urandom;
      send_update(3'($urandom), clock_ms, el, pick_level(), pick_level(), pick_level());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on the default registers: silence, extremes, hold expiry.
    send_update(3'd0, 32'd0, 16'd0, SILENCE, SILENCE, SILENCE);
    send_update(3'd0, 32'd10, 16'd10, -16'sd1000, -16'sd1000, -16'sd1000);
    send_update(3'd0, 32'd20, 16'd10, SILENCE, -16'sd3000, -16'sd2000);
    send_update(3'd0, 32'd1200, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_update(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'sh8001, 16'sh8001, 16'sh8001);
    send_update(3'd7, 32'd5, 16'd100, 16'sd0, -16'sd20000, -16'sd100);
    send_update(3'd7, 32'd2000, 16'd100, -16'sd500, -16'sd30000, -16'sd20000);
    send_update(3'd1, 32'd50, 16'd5, 16'sd256, 16'sd256, -16'sd2400);
    send_update(3'd1, 32'd60, 16'd10, -16'sd4000, -16'sd256, -16'sd6000);
    send_update(3'd2, 32'd70, 16'd10, -16'sd13000, 16'sd0, -16'sd3000);
    drain();

    // Extreme register settings, including unordered thresholds.
    write_reg(REG_MIN_LEVEL, 32'h0000_0100);
    write_reg(REG_MIN_INPUT, 32'h0000_8000);
    write_reg(REG_WARNING, 32'h0000_0000);
    write_reg(REG_ERROR, 32'h0000_8000);
    write_reg(REG_PEAK_DECAY, 32'h0000_FFFF);
    write_reg(REG_MAG_GAIN, 32'h0000_FFFF);
    write_reg(REG_PEAK_HOLD, 32'h0000_0000);
    write_reg(REG_INPUT_HOLD, 32'hFFFF_FFFF);
    send_update(3'd1, 32'd100, 16'd40, SILENCE, -16'sd9000, -16'sd100);
    send_update(3'd1, 32'd140, 16'd40, -16'sd100, -16'sd9100, -16'sd200);
    send_update(3'd3, 32'd150, 16'hFFFF, 16'sd100, 16'sd50, 16'sd0);
    random_updates(60);
    drain();

    write_reg(REG_MIN_LEVEL, 32'h0000_8000);
    write_reg(REG_MIN_INPUT, 32'h0000_0000);
    write_reg(REG_PEAK_DECAY, 32'h0000_0000);
    write_reg(REG_MAG_GAIN, 32'h0000_0000);
    write_reg(REG_PEAK_HOLD, 32'hFFFF_FFFF);
    write_reg(REG_INPUT_HOLD, 32'h0000_0000);
    send_idle_pct = 79;
    random_updates(60);
    drain();

    // Back to typical meter settings for the bulk of the traffic.
    write_reg(REG_MIN_LEVEL, 32'h0000_C400);
    write_reg(REG_MIN_INPUT, 32'h0000_CE00);
    write_reg(REG_WARNING, 32'h0000_EC00);
    write_reg(REG_ERROR, 32'h0000_F700);
    write_reg(REG_PEAK_DECAY, 32'd3011);
    write_reg(REG_MAG_GAIN, 32'd845);
    write_reg(REG_PEAK_HOLD, 32'd300);
    write_reg(REG_INPUT_HOLD, 32'd120);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_updates(130);
    send_idle_pct = 0; recv_stall_pct = 79;
    random_updates(130);
    drain();  // sender holds off until every result is back
    send_idle_pct = 25; recv_stall_pct = 25;
    random_updates(130);
    send_idle_pct = 79; recv_stall_pct = 0;
    random_updates(130);
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();

    if (meter_sb.errors == 0 && meter_sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
